/* sv/spmq_pkg.sv */
`default_nettype none
package spmq_pkg;

  // Queue geometry
  localparam int MaxLevels  = 8;
  localparam int LevelDepth = 16;
  localparam int ValueWidth = 32;

  // Derived widths
  localparam int LevelW = $clog2(MaxLevels);
  localparam int PtrW   = $clog2(LevelDepth);
  localparam int CountW = $clog2(LevelDepth + 1);
  localparam int ActW   = $clog2(MaxLevels + 1);
  localparam int AddrW  = $clog2(MaxLevels * LevelDepth);
  localparam int TotalW = 8;
  localparam int CfgW   = 4;
  localparam int CmdW   = 2;
  localparam int StatW  = 3;

  typedef enum logic [CmdW-1:0] {
    CmdPush      = 2'd0,
    CmdPop       = 2'd1,
    CmdTerminate = 2'd2,
    CmdNone      = 2'd3
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    StOk         = 3'd0,
    StTerminated = 3'd1,
    StEmpty      = 3'd2,
    StFull       = 3'd3,
    StBadLevel   = 3'd4
  } status_e;

  // Request from the controller to the entry store
  typedef struct packed {
    logic                  we;
    logic                  re;
    logic [AddrW-1:0]      addr;
    logic [ValueWidth-1:0] wdata;
  } mem_req_t;

  // Registered result of one request
  typedef struct packed {
    logic              done;
    status_e           status;
    logic              pop_ok;
    logic              all_empty;
    logic [TotalW-1:0] total;
  } result_t;

endpackage
`default_nettype wire

/* sv/strict_priority_multilevel_queue_core.sv */
`default_nettype none
// Strict-priority multilevel FIFO queue, 8 levels of 16 entries each.
// Requests: command_i (push, pop, terminate), level_i and data_value_i are
// taken at a rising edge with start high and busy low. busy is high for the
// one cycle in which the request executes, so a new request is not accepted
// while one is executing.
// Each request gives exactly one result: done_o is high for one cycle with
// status_o, popped_value_o, all_empty_o and total_count_o. done_o is
// registered and rises in the cycle after busy; the receiver cannot
// stall it, and the next request may be accepted at the edge ending that cycle.
// A pop reads the single-port memory in the execute cycle and its registered
// data is shown the following cycle.
// Pop picks the lowest non-empty level among the levels in use.
// cfg_we_i/cfg_wdata_i set the number of levels in use (reset 8); write only
// while no request is outstanding.
// Reset clears all pointers, counts and the terminated flag at once; the
// entry store is not cleared and needs no clearing pass.
module strict_priority_multilevel_queue_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [spmq_pkg::CmdW-1:0]         command_i,
  input  wire logic [spmq_pkg::LevelW-1:0]       level_i,
  input  wire logic [spmq_pkg::ValueWidth-1:0]   data_value_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [spmq_pkg::CfgW-1:0]         cfg_wdata_i,
  output logic                                   done_o,
  output logic [spmq_pkg::StatW-1:0]             status_o,
  output logic [spmq_pkg::ValueWidth-1:0]        popped_value_o,
  output logic                                   all_empty_o,
  output logic [spmq_pkg::TotalW-1:0]            total_count_o
);

  spmq_pkg::mem_req_t              mem_req;
  spmq_pkg::result_t               result;
  logic [spmq_pkg::ValueWidth-1:0] rdata;

  spmq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .command_i    (command_i),
    .level_i      (level_i),
    .data_value_i (data_value_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .mem_req_o    (mem_req),
    .result_o     (result)
  );

  spmq_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  // Result drive; popped value only on a successful pop
  assign done_o         = result.done;
  assign status_o       = result.status;
  assign popped_value_o = result.pop_ok ? rdata : '0;
  assign all_empty_o    = result.all_empty;
  assign total_count_o  = result.total;

endmodule
`default_nettype wire

/* sv/spmq_store.sv */
`default_nettype none
module spmq_store (
  input  wire logic                               clk_i,
  input  wire spmq_pkg::mem_req_t                 req_i,
  output logic [spmq_pkg::ValueWidth-1:0]         rdata_o
);

  logic [spmq_pkg::ValueWidth-1:0] mem [spmq_pkg::MaxLevels*spmq_pkg::LevelDepth];
  logic [spmq_pkg::ValueWidth-1:0] rdata_q;

  // Single port entry store, registered read
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* sv/spmq_ctrl.sv */
`default_nettype none
module spmq_ctrl (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [spmq_pkg::CmdW-1:0]         command_i,
  input  wire logic [spmq_pkg::LevelW-1:0]       level_i,
  input  wire logic [spmq_pkg::ValueWidth-1:0]   data_value_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [spmq_pkg::CfgW-1:0]         cfg_wdata_i,
  output spmq_pkg::mem_req_t                     mem_req_o,
  output spmq_pkg::result_t                      result_o
);

  // Request capture
  logic                            req_valid_q;
  spmq_pkg::cmd_e                  cmd_q;
  logic [spmq_pkg::LevelW-1:0]     level_q;
  logic [spmq_pkg::ValueWidth-1:0] data_q;

  // Queue bookkeeping
  logic [spmq_pkg::PtrW-1:0]   head_q  [spmq_pkg::MaxLevels];
  logic [spmq_pkg::PtrW-1:0]   tail_q  [spmq_pkg::MaxLevels];
  logic [spmq_pkg::CountW-1:0] count_q [spmq_pkg::MaxLevels];
  logic                        term_q;
  logic [spmq_pkg::CfgW-1:0]   levels_q;
  spmq_pkg::result_t           result_q;

  // Execute-stage decode
  logic [spmq_pkg::ActW-1:0]      active;
  logic [spmq_pkg::MaxLevels-1:0] nonempty;
  logic [spmq_pkg::MaxLevels-1:0] full;
  logic                           pop_found;
  logic [spmq_pkg::LevelW-1:0]    pop_lvl;
  logic [spmq_pkg::TotalW-1:0]    sum;
  logic                           push_ok;
  logic                           pop_ok;
  spmq_pkg::status_e              status;
  logic [spmq_pkg::TotalW-1:0]    total_d;
  spmq_pkg::mem_req_t             mem_req;

  // Clamp the level count to 1..MaxLevels
  always_comb begin
    if (levels_q == '0) begin
      active = spmq_pkg::ActW'(1);
    end else if (levels_q > spmq_pkg::CfgW'(spmq_pkg::MaxLevels)) begin
      active = spmq_pkg::ActW'(spmq_pkg::MaxLevels);
    end else begin
      active = spmq_pkg::ActW'(levels_q);
    end
  end

  // Per-level flags, sum over active levels, priority pick
  always_comb begin
    sum       = '0;
    pop_found = 1'b0;
    pop_lvl   = '0;
    for (int i = 0; i < spmq_pkg::MaxLevels; i++) begin
      full[i]     = (count_q[i] == spmq_pkg::CountW'(spmq_pkg::LevelDepth));
      nonempty[i] = (count_q[i] != '0) && (spmq_pkg::ActW'(i) < active);
      if (spmq_pkg::ActW'(i) < active) begin
        sum = sum + spmq_pkg::TotalW'(count_q[i]);
      end
    end
    // highest index first so the lowest non-empty level wins
    for (int i = spmq_pkg::MaxLevels - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        pop_found = 1'b1;
        pop_lvl   = spmq_pkg::LevelW'(i);
      end
    end
  end

  // Command decision
  always_comb begin
    push_ok = 1'b0;
    pop_ok  = 1'b0;
    status  = spmq_pkg::StOk;
    case (cmd_q)
      spmq_pkg::CmdPush: begin
        if (term_q) begin
          status = spmq_pkg::StTerminated;
        end else if (spmq_pkg::ActW'(level_q) >= active) begin
          status = spmq_pkg::StBadLevel;
        end else if (full[level_q]) begin
          status = spmq_pkg::StFull;
        end else begin
          push_ok = 1'b1;
        end
      end
      spmq_pkg::CmdPop: begin
        if (term_q) begin
          status = spmq_pkg::StTerminated;
        end else if (!pop_found) begin
          status = spmq_pkg::StEmpty;
        end else begin
          pop_ok = 1'b1;
        end
      end
      default: begin
        status = spmq_pkg::StOk;
      end
    endcase
    push_ok = push_ok && req_valid_q;
    pop_ok  = pop_ok && req_valid_q;

    if (push_ok) begin
      total_d = sum + spmq_pkg::TotalW'(1);
    end else if (pop_ok) begin
      total_d = sum - spmq_pkg::TotalW'(1);
    end else begin
      total_d = sum;
    end
  end

  // Entry store access: write at tail on push, read at head on pop
  always_comb begin
    mem_req.we    = push_ok;
    mem_req.re    = pop_ok;
    mem_req.wdata = data_q;
    if (pop_ok) begin
      mem_req.addr = spmq_pkg::AddrW'(pop_lvl) * spmq_pkg::AddrW'(spmq_pkg::LevelDepth)
                   + spmq_pkg::AddrW'(head_q[pop_lvl]);
    end else begin
      mem_req.addr = spmq_pkg::AddrW'(level_q) * spmq_pkg::AddrW'(spmq_pkg::LevelDepth)
                   + spmq_pkg::AddrW'(tail_q[level_q]);
    end
  end

  // Control and bookkeeping registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      term_q      <= 1'b0;
      levels_q    <= spmq_pkg::CfgW'(spmq_pkg::MaxLevels);
      result_q    <= '0;
      for (int i = 0; i < spmq_pkg::MaxLevels; i++) begin
        head_q[i]  <= '0;
        tail_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else begin
      req_valid_q <= start && !req_valid_q;
      if (cfg_we_i) begin
        levels_q <= cfg_wdata_i;
      end
      if (req_valid_q && (cmd_q == spmq_pkg::CmdTerminate)) begin
        term_q <= 1'b1;
      end
      for (int i = 0; i < spmq_pkg::MaxLevels; i++) begin
        if (push_ok && (level_q == spmq_pkg::LevelW'(i))) begin
          tail_q[i]  <= (tail_q[i] == spmq_pkg::PtrW'(spmq_pkg::LevelDepth - 1))
                        ? '0 : tail_q[i] + spmq_pkg::PtrW'(1);
          count_q[i] <= count_q[i] + spmq_pkg::CountW'(1);
        end
        if (pop_ok && (pop_lvl == spmq_pkg::LevelW'(i))) begin
          head_q[i]  <= (head_q[i] == spmq_pkg::PtrW'(spmq_pkg::LevelDepth - 1))
                        ? '0 : head_q[i] + spmq_pkg::PtrW'(1);
          count_q[i] <= count_q[i] - spmq_pkg::CountW'(1);
        end
      end
      result_q.done      <= req_valid_q;
      result_q.status    <= status;
      result_q.pop_ok    <= pop_ok;
      result_q.all_empty <= (total_d == '0);
      result_q.total     <= total_d;
    end
  end

  // Request payload capture, no reset needed
  always_ff @(posedge clk_i) begin
    if (start && !req_valid_q) begin
      cmd_q   <= spmq_pkg::cmd_e'(command_i);
      level_q <= level_i;
      data_q  <= data_value_i;
    end
  end

  assign busy      = req_valid_q;
  assign mem_req_o = mem_req;
  assign result_o  = result_q;

  // Every executed request reports its result in the next cycle
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_q |=> result_q.done)
    else $error("executed request produced no result");

  // A request never occupies the execute stage twice
  a_one_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_q |=> !req_valid_q)
    else $error("execute stage held across two cycles");

  // Terminate is sticky until reset
  a_term_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    term_q |=> term_q)
    else $error("terminated flag cleared");

  // A successful pop reports ok status
  a_pop_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_q.done && result_q.pop_ok) |-> (result_q.status == spmq_pkg::StOk))
    else $error("pop data with non-ok status");

  // Store never touched after terminate
  a_term_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    term_q |-> (!mem_req.we && !mem_req.re))
    else $error("store access after terminate");

endmodule
`default_nettype wire

/* tb/spmq_checker.sv */
`timescale 1ns / 100ps

// Watches the request and response channels of the priority queue, keeps a
// shadow copy of the queue state and compares every response in order.
module spmq_checker
  import spmq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  logic [CmdW-1:0]       command_i,
  input  logic [LevelW-1:0]     level_i,
  input  logic [ValueWidth-1:0] data_value_i,
  input  logic                  cfg_we_i,
  input  logic [CfgW-1:0]       cfg_wdata_i,
  input  logic                  done_i,
  input  logic [StatW-1:0]      status_i,
  input  logic [ValueWidth-1:0] popped_value_i,
  input  logic                  all_empty_i,
  input  logic [TotalW-1:0]     total_count_i,
  output int                    outstanding_o,
  output int                    errors_o
);

  typedef struct {
    status_e               status;
    logic [ValueWidth-1:0] popped;
    logic                  all_empty;
    logic [TotalW-1:0]     total;
  } queue_resp_t;

  // Shadow queue state
  logic [ValueWidth-1:0] slots    [MaxLevels][LevelDepth];
  logic [PtrW-1:0]       head_ptr [MaxLevels];
  logic [PtrW-1:0]       tail_ptr [MaxLevels];
  logic [CountW-1:0]     fill     [MaxLevels];
  logic                  halted;
  logic [CfgW-1:0]       levels_cfg;

  queue_resp_t expected_resps[$];
  queue_resp_t want;
  int          err_count = 0;

  assign errors_o = err_count;

  // Apply one request to the shadow state and return its response
  function automatic queue_resp_t predict_response(cmd_e cmd, logic [LevelW-1:0] lvl,
                                                   logic [ValueWidth-1:0] value);
    queue_resp_t r;
    int          act;
    int          sum;
    bit          found;
    r.status = StOk;
    r.popped = '0;
    sum      = 0;
    found    = 1'b0;
    // register value 0 behaves as one level, anything above the max as the max
    if (levels_cfg == 0) act = 1;
    else if (levels_cfg > MaxLevels) act = MaxLevels;
    else act = int'(levels_cfg);

    case (cmd)
      CmdPush: begin
        if (halted) r.status = StTerminated;
        else if (lvl >= act) r.status = StBadLevel;
        else if (fill[lvl] >= LevelDepth) r.status = StFull;
        else begin
          slots[lvl][tail_ptr[lvl]] = value;
          tail_ptr[lvl] = tail_ptr[lvl] + PtrW'(1);
          fill[lvl] = fill[lvl] + CountW'(1);
        end
      end
      CmdPop: begin
        if (halted) r.status = StTerminated;
        else begin
          r.status = StEmpty;
          // lowest-numbered non-empty level wins
          for (int i = 0; i < act; i++) begin
            if (!found && fill[i] != 0) begin
              r.popped    = slots[i][head_ptr[i]];
              head_ptr[i] = head_ptr[i] + PtrW'(1);
              fill[i]     = fill[i] - CountW'(1);
              r.status    = StOk;
              found       = 1'b1;
            end
          end
        end
      end
      CmdTerminate: halted = 1'b1;
      default: ;
    endcase

    // hidden levels are left out of the totals
    for (int i = 0; i < act; i++) sum += int'(fill[i]);
    r.all_empty = (sum == 0);
    r.total     = sum[TotalW-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxLevels; i++) begin
        head_ptr[i] = '0;
        tail_ptr[i] = '0;
        fill[i]     = '0;
      end
      halted     = 1'b0;
      levels_cfg = CfgW'(MaxLevels);
      expected_resps.delete();
      outstanding_o <= 0;
    end else begin
      // response side: compare against the oldest request
      if (done_i) begin
        if (expected_resps.size() == 0) begin
          $error("response with no request outstanding");
          err_count++;
        end else begin
          want = expected_resps.pop_front();
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            err_count++;
          end
          if (popped_value_i !== want.popped) begin
            $error("popped_value: expected %h, got %h", want.popped, popped_value_i);
            err_count++;
          end
          if (all_empty_i !== want.all_empty) begin
            $error("all_empty: expected %0d, got %0d", want.all_empty, all_empty_i);
            err_count++;
          end
          if (total_count_i !== want.total) begin
            $error("total_count: expected %0d, got %0d", want.total, total_count_i);
            err_count++;
          end
        end
      end

      if (cfg_we_i) levels_cfg = cfg_wdata_i;

      // request side
      if (start_i && !busy_i)
        expected_resps.push_back(predict_response(cmd_e'(command_i), level_i, data_value_i));

      outstanding_o <= expected_resps.size();
    end
  end

endmodule

/* tb/tb_strict_priority_multilevel_queue_core.sv */
`timescale 1ns / 100ps

module tb_strict_priority_multilevel_queue_core;
  import spmq_pkg::*;

  localparam int RandomItems = 1150;
  localparam int CycleLimit  = 200000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [CmdW-1:0]       command_i;
  logic [LevelW-1:0]     level_i;
  logic [ValueWidth-1:0] data_value_i;
  logic                  cfg_we_i;
  logic [CfgW-1:0]       cfg_wdata_i;
  logic                  done_o;
  logic [StatW-1:0]      status_o;
  logic [ValueWidth-1:0] popped_value_o;
  logic                  all_empty_o;
  logic [TotalW-1:0]     total_count_o;

  int outstanding;
  int errors;
  int cycles = 0;
  bit steady = 1'b0;      // no sender idling while set
  int active_now = MaxLevels;

  strict_priority_multilevel_queue_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .level_i        (level_i),
    .data_value_i   (data_value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .popped_value_o (popped_value_o),
    .all_empty_o    (all_empty_o),
    .total_count_o  (total_count_o)
  );

  spmq_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .command_i      (command_i),
    .level_i        (level_i),
    .data_value_i   (data_value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_i         (done_o),
    .status_i       (status_o),
    .popped_value_i (popped_value_o),
    .all_empty_i    (all_empty_o),
    .total_count_i  (total_count_o),
    .outstanding_o  (outstanding),
    .errors_o       (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Present one request and hold it until accepted; start stays high on return
  task automatic send_request(input cmd_e c, input logic [LevelW-1:0] l,
                              input logic [ValueWidth-1:0] d);
    while (!steady && $urandom_range(99) < 8) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start        <= 1'b1;
    command_i    <= c;
    level_i      <= l;
    data_value_i <= d;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Stop sending and wait for every response, then let the block settle
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_levels(input logic [CfgW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (v == 0) active_now = 1;
    else if (v > MaxLevels) active_now = MaxLevels;
    else active_now = int'(v);
  endtask

  // Mostly legal pushes and pops, biased toward one hot level, with some noise
  task automatic random_request(input int push_pct, input int hot);
    int                    r;
    cmd_e                  c;
    logic [LevelW-1:0]     l;
    logic [ValueWidth-1:0] d;
    r = $urandom_range(99);
    if (r < 3) c = CmdNone;
    else if (r < 3 + push_pct * 97 / 100) c = CmdPush;
    else c = CmdPop;
    case ($urandom_range(9))
      0:       d = '0;
      1:       d = '1;
      default: d = $urandom;
    endcase
    r = $urandom_range(99);
    if (r < 8) l = LevelW'($urandom_range(MaxLevels - 1));
    else if (r < 50) l = LevelW'(hot);
    else l = LevelW'($urandom_range(active_now - 1));
    send_request(c, l, d);
  endtask

  initial begin : stimulus
    int              sent;
    int              phase_idx;
    int              len;
    int              push_pct;
    int              hot;
    int              r;
    logic [CfgW-1:0] cfg;
    rst_ni       = 1'b0;
    start        = 1'b0;
    command_i    = CmdNone;
    level_i      = '0;
    data_value_i = '0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty pop, extreme values, FIFO order and level priority
    send_request(CmdPop, 3'd0, '0);
    send_request(CmdPush, 3'd0, '0);
    send_request(CmdPush, 3'd7, '1);
    send_request(CmdPush, 3'd3, 32'hA5A5_A5A5);
    send_request(CmdPush, 3'd3, 32'h5A5A_5A5A);
    send_request(CmdNone, 3'd5, 32'h1234_5678);
    repeat (5) send_request(CmdPop, 3'd0, '0);
    send_request(CmdPush, 3'd6, 32'hDEAD_BEEF);
    wait_idle();
    // Fewer levels: bad level, hidden contents left out of the totals
    write_levels(4'd2);
    send_request(CmdPush, 3'd6, 32'h0BAD_0BAD);
    send_request(CmdPush, 3'd1, 32'h1111_1111);
    send_request(CmdPop, 3'd0, '0);
    send_request(CmdPop, 3'd0, '0);
    wait_idle();
    // Raising the count again exposes the hidden entry
    write_levels(4'd8);
    send_request(CmdPop, 3'd0, '0);
    send_request(CmdPop, 3'd0, '0);

    // Random phases, each under its own level count
    sent      = 0;
    phase_idx = 0;
    while (sent < RandomItems) begin
      wait_idle();
      case (phase_idx)
        0: cfg = 4'd1;
        1: cfg = 4'd0;
        2: cfg = 4'd15;
        3: cfg = 4'd8;
        default: begin
          r = $urandom_range(9);
          if (r == 0) cfg = 4'd0;
          else if (r == 1) cfg = CfgW'($urandom_range(9, 15));
          else cfg = CfgW'($urandom_range(1, MaxLevels));
        end
      endcase
      write_levels(cfg);
      steady = (phase_idx == 5);
      len    = steady ? 200 : $urandom_range(40, 120);
      case ($urandom_range(2))
        0:       push_pct = 90;
        1:       push_pct = 25;
        default: push_pct = 55;
      endcase
      hot = $urandom_range(active_now - 1);
      repeat (len) begin
        random_request(push_pct, hot);
        sent++;
      end
      phase_idx++;
    end
    steady = 1'b0;

    // Terminate last: it sticks until reset
    wait_idle();
    send_request(CmdTerminate, 3'd0, '0);
    send_request(CmdPush, 3'd0, 32'hCAFE_F00D);
    send_request(CmdPop, 3'd0, '0);
    send_request(CmdNone, 3'd2, '0);
    send_request(CmdTerminate, 3'd7, '1);
    repeat (20) random_request(50, 0);
    wait_idle();
    repeat (4) @(posedge clk_i);

    if (errors == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/spmq_pkg.sv
sv/spmq_store.sv
sv/spmq_ctrl.sv
sv/strict_priority_multilevel_queue_core.sv
tb/spmq_checker.sv
tb/tb_strict_priority_multilevel_queue_core.sv
